// ===== src/stt_pkg.sv =====
// Shared types, codes and character helpers for the source text tokenizer.
package stt_pkg;

  // Text offsets saturate at the smaller of MAX_TEXT-1 and the 16-bit limit
  localparam int MAX_TEXT = 65536;
  localparam logic [15:0] OFFSET_CAP =
    (MAX_TEXT - 1 > 65535) ? 16'hFFFF : 16'(MAX_TEXT - 1);
  localparam logic [15:0] LEN_CAP   = 16'hFFFF;
  localparam logic [62:0] VALUE_MAX = {63{1'b1}};

  // Scanner modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_NUMBER  = 3'd1;
  localparam logic [2:0] M_IDENT   = 3'd2;
  localparam logic [2:0] M_STRING  = 3'd3;
  localparam logic [2:0] M_VARNAME = 3'd4;
  localparam logic [2:0] M_HALT    = 3'd5;

  // Token kinds
  localparam logic [4:0] K_NEWLINE = 5'd0;
  localparam logic [4:0] K_COLON   = 5'd1;
  localparam logic [4:0] K_COMMA   = 5'd2;
  localparam logic [4:0] K_EQUAL   = 5'd3;
  localparam logic [4:0] K_PLUS    = 5'd4;
  localparam logic [4:0] K_MINUS   = 5'd5;
  localparam logic [4:0] K_SLASH   = 5'd6;
  localparam logic [4:0] K_STAR    = 5'd7;
  localparam logic [4:0] K_LPAREN  = 5'd8;
  localparam logic [4:0] K_RPAREN  = 5'd9;
  localparam logic [4:0] K_LBRACK  = 5'd10;
  localparam logic [4:0] K_RBRACK  = 5'd11;
  localparam logic [4:0] K_LBRACE  = 5'd12;
  localparam logic [4:0] K_RBRACE  = 5'd13;
  localparam logic [4:0] K_BANG    = 5'd14;
  localparam logic [4:0] K_NUMBER  = 5'd15;
  localparam logic [4:0] K_UQWORD  = 5'd16;
  localparam logic [4:0] K_RETURN  = 5'd17;
  localparam logic [4:0] K_IDENT   = 5'd18;
  localparam logic [4:0] K_STRING  = 5'd19;
  localparam logic [4:0] K_VARNAME = 5'd20;
  localparam logic [4:0] K_END     = 5'd21;
  localparam logic [4:0] K_BADCHAR = 5'd22;
  localparam logic [4:0] K_UNTERM  = 5'd23;

  // Characters with a role of their own
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Token queue between scanner and emitter
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } tok_t;

  // One queue entry holds everything one byte produces: a flushed token
  // (the only one that can carry a value) and a terminal token.
  typedef struct packed {
    logic        a_v;
    tok_t        a;
    logic [62:0] a_value;
    logic        b_v;
    tok_t        b;
  } stt_entry_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [15:0] inc_sat(input logic [15:0] v, input logic [15:0] cap);
    return (v >= cap) ? cap : v + 16'd1;
  endfunction

  // Letters of "uqword" and "return" by position
  function automatic logic [7:0] uq_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h75; // u
      3'd1:    c = 8'h71; // q
      3'd2:    c = 8'h77; // w
      3'd3:    c = 8'h6F; // o
      3'd4:    c = 8'h72; // r
      3'd5:    c = 8'h64; // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ret_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h72; // r
      3'd1:    c = 8'h65; // e
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h75; // u
      3'd4:    c = 8'h72; // r
      3'd5:    c = 8'h6E; // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Punctuation table: {found, kind}
  function automatic logic [5:0] punct_lookup(input logic [7:0] b);
    logic [5:0] r;
    unique case (b)
      8'h0A:   r = {1'b1, K_NEWLINE};
      8'h3A:   r = {1'b1, K_COLON};
      8'h2C:   r = {1'b1, K_COMMA};
      8'h3D:   r = {1'b1, K_EQUAL};
      8'h2B:   r = {1'b1, K_PLUS};
      8'h2D:   r = {1'b1, K_MINUS};
      8'h2F:   r = {1'b1, K_SLASH};
      8'h2A:   r = {1'b1, K_STAR};
      8'h28:   r = {1'b1, K_LPAREN};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h5B:   r = {1'b1, K_LBRACK};
      8'h5D:   r = {1'b1, K_RBRACK};
      8'h7B:   r = {1'b1, K_LBRACE};
      8'h7D:   r = {1'b1, K_RBRACE};
      8'h21:   r = {1'b1, K_BANG};
      default: r = {1'b0, K_BADCHAR};
    endcase
    return r;
  endfunction

endpackage

// ===== src/stt_front.sv =====
// Scanner: classifies each byte, tracks the pending token, builds queue entries.
module stt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          text_byte,
  output logic                enq,
  output stt_pkg::stt_entry_t ent
);
  import stt_pkg::*;

  logic [2:0]  mode_r,  mode_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [15:0] pstart_r, pstart_nxt;
  logic [15:0] plen_r,  plen_nxt;
  logic [62:0] acc_r,   acc_nxt;
  logic [1:0]  kw_r,    kw_nxt;

  logic        handled;
  logic        stop;
  logic        at_end;
  logic [5:0]  pl;
  logic [66:0] prod;
  logic [2:0]  kpos;
  logic        alpha;
  logic        digit;

  assign alpha = is_alpha(text_byte);
  assign digit = is_digit(text_byte);
  assign pl    = punct_lookup(text_byte);
  assign kpos  = plen_r[2:0];

  // acc*10 + digit; saturates when the result passes the largest value
  assign prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {63'd0, text_byte[3:0]};

  // Next-state and token build
  always_comb begin
    mode_nxt   = mode_r;
    offset_nxt = offset_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    acc_nxt    = acc_r;
    kw_nxt     = kw_r;
    ent        = '0;
    handled    = 1'b0;
    stop       = 1'b0;
    at_end     = 1'b0;

    if (take && mode_r != M_HALT) begin
      // continue or flush the pending token
      if (mode_r == M_STRING) begin
        handled = 1'b1;
        if (text_byte == CH_NUL) begin
          ent.a_v  = 1'b1;
          ent.a    = '{kind: K_UNTERM, start: pstart_r, length: plen_r};
          mode_nxt = M_HALT;
          stop     = 1'b1;
        end else if (text_byte == CH_QUOTE) begin
          ent.a_v  = 1'b1;
          ent.a    = '{kind: K_STRING, start: pstart_r, length: plen_r};
          mode_nxt = M_IDLE;
        end else begin
          plen_nxt = inc_sat(plen_r, LEN_CAP);
        end
      end else if (mode_r == M_NUMBER) begin
        if (digit) begin
          acc_nxt  = (prod > {4'd0, VALUE_MAX}) ? VALUE_MAX : prod[62:0];
          plen_nxt = inc_sat(plen_r, LEN_CAP);
          handled  = 1'b1;
        end else begin
          ent.a_v     = 1'b1;
          ent.a       = '{kind: K_NUMBER, start: pstart_r, length: plen_r};
          ent.a_value = acc_r;
          mode_nxt    = M_IDLE;
        end
      end else if (mode_r == M_IDENT) begin
        if (alpha || digit) begin
          if (plen_r >= 16'd6) begin
            kw_nxt = 2'b00;
          end else begin
            kw_nxt = kw_r & {text_byte == ret_char(kpos), text_byte == uq_char(kpos)};
          end
          plen_nxt = inc_sat(plen_r, LEN_CAP);
          handled  = 1'b1;
        end else begin
          ent.a_v = 1'b1;
          ent.a   = '{kind: K_IDENT, start: pstart_r, length: plen_r};
          if (plen_r == 16'd6) begin
            if (kw_r[0]) begin
              ent.a.kind = K_UQWORD;
            end else if (kw_r[1]) begin
              ent.a.kind = K_RETURN;
            end
          end
          mode_nxt = M_IDLE;
        end
      end else if (mode_r == M_VARNAME) begin
        if (alpha || (digit && plen_r != 16'd0)) begin
          plen_nxt = inc_sat(plen_r, LEN_CAP);
          handled  = 1'b1;
        end else begin
          ent.a_v  = 1'b1;
          ent.a    = '{kind: K_VARNAME, start: pstart_r, length: plen_r};
          mode_nxt = M_IDLE;
        end
      end

      // byte starts something new or stands alone
      if (!handled) begin
        if (text_byte == CH_NUL) begin
          ent.b_v  = 1'b1;
          ent.b    = '{kind: K_END, start: offset_r, length: 16'd0};
          mode_nxt = M_IDLE;
          at_end   = 1'b1;
        end else if (text_byte == CH_SPACE) begin
          // skipped
        end else if (text_byte == CH_DOLLAR) begin
          mode_nxt   = M_NUMBER;
          pstart_nxt = inc_sat(offset_r, OFFSET_CAP);
          plen_nxt   = 16'd0;
          acc_nxt    = '0;
        end else if (alpha) begin
          mode_nxt   = M_IDENT;
          pstart_nxt = offset_r;
          plen_nxt   = 16'd1;
          kw_nxt     = {text_byte == ret_char(3'd0), text_byte == uq_char(3'd0)};
        end else if (text_byte == CH_QUOTE) begin
          mode_nxt   = M_STRING;
          pstart_nxt = inc_sat(offset_r, OFFSET_CAP);
          plen_nxt   = 16'd0;
        end else if (text_byte == CH_PERCENT) begin
          mode_nxt   = M_VARNAME;
          pstart_nxt = inc_sat(offset_r, OFFSET_CAP);
          plen_nxt   = 16'd0;
        end else if (pl[5]) begin
          ent.b_v = 1'b1;
          ent.b   = '{kind: pl[4:0], start: offset_r, length: 16'd1};
        end else begin
          ent.b_v  = 1'b1;
          ent.b    = '{kind: K_BADCHAR, start: offset_r, length: 16'd1};
          mode_nxt = M_HALT;
        end
      end

      // offset: restarts after end of text, frozen on an unterminated string
      if (at_end) begin
        offset_nxt = 16'd0;
      end else if (!stop) begin
        offset_nxt = inc_sat(offset_r, OFFSET_CAP);
      end
    end
  end

  assign enq = ent.a_v || ent.b_v;

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      offset_r <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      acc_r    <= '0;
      kw_r     <= 2'b11;
    end else begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      acc_r    <= acc_nxt;
      kw_r     <= kw_nxt;
    end
  end

endmodule

// ===== src/stt_queue.sv =====
// Short entry queue between scanner and emitter.
module stt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enq,
  input  stt_pkg::stt_entry_t wdata,
  input  logic                deq,
  output stt_pkg::stt_entry_t head,
  output logic                empty,
  output logic                full
);
  import stt_pkg::*;

  stt_entry_t          slot_r [Q_DEPTH];
  logic [Q_AW-1:0]     wr_r;
  logic [Q_AW-1:0]     rd_r;
  logic [Q_AW:0]       cnt_r;
  logic                do_enq;
  logic                do_deq;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign do_enq = enq && !full;
  assign do_deq = deq && !empty;
  assign head   = slot_r[rd_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_enq) begin
      slot_r[wr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_enq) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_deq) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_enq && !do_deq) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_deq && !do_enq) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/stt_back.sv =====
// Emitter: delivers the one or two tokens of each queue entry in order.
module stt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  stt_pkg::stt_entry_t head,
  input  logic                q_empty,
  input  logic                pop,
  output logic                deq,
  output logic [4:0]          token_kind,
  output logic [15:0]         token_start,
  output logic [15:0]         token_length,
  output logic [62:0]         number_value,
  output logic                last_of_run
);
  import stt_pkg::*;

  logic first_done_r;
  logic show_a;
  logic beat;

  // flushed token first, then the terminal token
  assign show_a = head.a_v && !first_done_r;
  assign beat   = pop && !q_empty;
  assign deq    = beat && !(show_a && head.b_v);

  assign token_kind   = show_a ? head.a.kind   : head.b.kind;
  assign token_start  = show_a ? head.a.start  : head.b.start;
  assign token_length = show_a ? head.a.length : head.b.length;
  assign number_value = show_a ? head.a_value  : '0;
  assign last_of_run  = show_a ? !head.b_v     : 1'b1;

  // Tracks that the first of two tokens has gone out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_done_r <= 1'b0;
    end else if (beat) begin
      first_done_r <= show_a && head.b_v;
    end
  end

endmodule

// ===== src/source_text_tokenizer.sv =====
// A token reaches the result ports once the queue entry that its byte wrote is at the head.
// Throughput: one byte per cycle while full is low; a byte that yields a flushed token plus its own
// token delivers them on separate result beats, and the four-entry token queue absorbs the burst.
// Reset: synchronous active-low rst_n clears scanner state, offsets and the queue;
// after an error token the block takes bytes but emits nothing until reset.
module source_text_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_text_byte,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [62:0] out_number_value,
  output logic        out_last_of_run
);
  import stt_pkg::*;

  stt_entry_t ent;
  stt_entry_t head;
  logic       enq;
  logic       deq;
  logic       q_full;
  logic       q_empty;
  logic       take;

  assign take  = push && !q_full;
  assign full  = q_full;
  assign empty = q_empty;

  stt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .text_byte (in_text_byte),
    .enq       (enq),
    .ent       (ent)
  );

  stt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .enq   (enq),
    .wdata (ent),
    .deq   (deq),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  stt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .deq          (deq),
    .token_kind   (out_token_kind),
    .token_start  (out_token_start),
    .token_length (out_token_length),
    .number_value (out_number_value),
    .last_of_run  (out_last_of_run)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the source text tokenizer: directed texts, long text, random texts.
`timescale 1ns / 100ps

module tb_top;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int STALL_CYCLES = 60;
  localparam int REPORT_MAX   = 10;
  localparam int LONG_BODY    = 40;
  localparam logic [47:0] UQ_TEXT  = "uqword";
  localparam logic [47:0] RET_TEXT = "return";
  localparam string PUNCT_TEXT = "\n:,=+-/*()[]{}!";

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] offset;
    logic [15:0] pstart;
    logic [15:0] plen;
    logic [62:0] acc;
    logic [1:0]  kw;
  } scan_state_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [62:0] value;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_text_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [62:0] out_number_value;
  logic        out_last_of_run;

  scan_state_t scanner = '{mode: M_IDLE, offset: '0, pstart: '0, plen: '0, acc: '0, kw: 2'b11};
  token_t      expected_tokens [$];
  int          mismatches = 0;
  int          chars_sent = 0;
  int          stall_requests = 0;
  int          cycle_count = 0;
  bit          steady = 1'b0;

  string near_words [8] = '{"uqword", "return", "uqwor", "retur", "returnx", "Return",
                            "uqworx", "uqword_1"};

  source_text_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_text_byte     (in_text_byte),
    .empty            (empty),
    .pop              (pop),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_number_value (out_number_value),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- scanner model

  function automatic logic letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v, input logic [15:0] cap);
    return (v >= cap) ? cap : v + 16'd1;
  endfunction

  // Drop keyword candidates that the letter at this position rules out
  function automatic logic [1:0] next_kw(input logic [1:0] kw, input logic [15:0] pos,
                                         input logic [7:0] b);
    logic [1:0] k;
    k = kw;
    if (pos >= 16'd6) return 2'b00;
    if (b != UQ_TEXT[47 - 8 * pos[2:0] -: 8]) k[0] = 1'b0;
    if (b != RET_TEXT[47 - 8 * pos[2:0] -: 8]) k[1] = 1'b0;
    return k;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    case (b)
      "\n":    return K_NEWLINE;
      ":":     return K_COLON;
      ",":     return K_COMMA;
      "=":     return K_EQUAL;
      "+":     return K_PLUS;
      "-":     return K_MINUS;
      "/":     return K_SLASH;
      "*":     return K_STAR;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "[":     return K_LBRACK;
      "]":     return K_RBRACK;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      "!":     return K_BANG;
      default: return K_BADCHAR;
    endcase
  endfunction

  function automatic token_t make_tok(input logic [4:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic [62:0] value);
    return '{kind: kind, start: start, length: len, value: value, last: 1'b0};
  endfunction

  // Advance the scanner by one byte; returns the tokens it yields (at most two)
  function automatic int scan_byte(inout scan_state_t s, input logic [7:0] b,
                                   output token_t t0, output token_t t1);
    token_t      tk [2];
    int          n;
    logic [15:0] pos;
    logic [63:0] d;
    logic [4:0]  kind;
    logic        handled;
    logic        rewind;
    n = 0;
    pos = s.offset;
    handled = 1'b0;
    rewind = 1'b0;
    tk[0] = '0;
    tk[1] = '0;
    t0 = '0;
    t1 = '0;
    if (s.mode == M_HALT) return 0;

    // Continue or flush the token in progress
    if (s.mode == M_STRING) begin
      handled = 1'b1;
      if (b == CH_NUL) begin
        tk[n] = make_tok(K_UNTERM, s.pstart, s.plen, '0);
        n++;
        s.mode = M_HALT;
      end else if (b == CH_QUOTE) begin
        tk[n] = make_tok(K_STRING, s.pstart, s.plen, '0);
        n++;
        s.mode = M_IDLE;
      end else begin
        s.plen = bump(s.plen, LEN_CAP);
      end
    end else if (s.mode == M_NUMBER && digit(b)) begin
      d = 64'(b) - 64'h30;
      if (64'(s.acc) > (64'(VALUE_MAX) - d) / 64'd10) s.acc = VALUE_MAX;
      else s.acc = 63'(64'(s.acc) * 64'd10 + d);
      s.plen = bump(s.plen, LEN_CAP);
      handled = 1'b1;
    end else if (s.mode == M_IDENT && (letter(b) || digit(b))) begin
      s.kw = next_kw(s.kw, s.plen, b);
      s.plen = bump(s.plen, LEN_CAP);
      handled = 1'b1;
    end else if (s.mode == M_VARNAME && (letter(b) || (s.plen != 16'd0 && digit(b)))) begin
      s.plen = bump(s.plen, LEN_CAP);
      handled = 1'b1;
    end else if (s.mode == M_NUMBER) begin
      tk[n] = make_tok(K_NUMBER, s.pstart, s.plen, s.acc);
      n++;
      s.mode = M_IDLE;
    end else if (s.mode == M_IDENT) begin
      kind = K_IDENT;
      if (s.plen == 16'd6 && s.kw[0]) kind = K_UQWORD;
      else if (s.plen == 16'd6 && s.kw[1]) kind = K_RETURN;
      tk[n] = make_tok(kind, s.pstart, s.plen, '0);
      n++;
      s.mode = M_IDLE;
    end else if (s.mode == M_VARNAME) begin
      tk[n] = make_tok(K_VARNAME, s.pstart, s.plen, '0);
      n++;
      s.mode = M_IDLE;
    end

    // The byte itself, when not absorbed above
    if (!handled) begin
      if (b == CH_NUL) begin
        tk[n] = make_tok(K_END, pos, 16'd0, '0);
        n++;
        s.offset = '0;
        s.mode = M_IDLE;
        rewind = 1'b1;
      end else if (b == CH_SPACE) begin
        // whitespace only moves the offset
      end else if (b == CH_DOLLAR) begin
        s.mode = M_NUMBER;
        s.pstart = bump(pos, OFFSET_CAP);
        s.plen = '0;
        s.acc = '0;
      end else if (letter(b)) begin
        s.mode = M_IDENT;
        s.pstart = pos;
        s.plen = 16'd1;
        s.kw = next_kw(2'b11, 16'd0, b);
      end else if (b == CH_QUOTE) begin
        s.mode = M_STRING;
        s.pstart = bump(pos, OFFSET_CAP);
        s.plen = '0;
      end else if (b == CH_PERCENT) begin
        s.mode = M_VARNAME;
        s.pstart = bump(pos, OFFSET_CAP);
        s.plen = '0;
      end else begin
        kind = punct_kind(b);
        tk[n] = make_tok(kind, pos, 16'd1, '0);
        n++;
        if (kind == K_BADCHAR) s.mode = M_HALT;
      end
    end

    if (!rewind) s.offset = bump(pos, OFFSET_CAP);
    if (n > 0) tk[n - 1].last = 1'b1;
    t0 = tk[0];
    t1 = tk[1];
    return n;
  endfunction

  function automatic bit would_halt(input logic [7:0] b);
    scan_state_t probe;
    token_t      t0, t1;
    probe = scanner;
    void'(scan_byte(probe, b, t0, t1));
    return probe.mode == M_HALT;
  endfunction

  // ---------------------------------------------------------------- driving

  // Offer one byte; idles at random first, returns once the beat is taken
  task automatic send_char(input logic [7:0] b);
    token_t t0, t1;
    int     n;
    while (!steady && $urandom_range(99) < 9) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    n = scan_byte(scanner, b, t0, t1);
    if (n > 0) expected_tokens.push_back(t0);
    if (n > 1) expected_tokens.push_back(t1);
    chars_sent++;
  endtask

  // Random texts must not stop the block early: a halting byte becomes a space
  task automatic send_char_safe(input logic [7:0] b);
    if (would_halt(b)) send_char(CH_SPACE);
    else send_char(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Receiver: random pop, long hold-off on request
  initial begin
    int hold;
    int served;
    hold = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (served != stall_requests) begin
        served = stall_requests;
        hold = STALL_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_token(input string what, input token_t want, input token_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s: exp kind=%0d start=%0d len=%0d value=%0d last=%0b", what,
               want.kind, want.start, want.length, want.value, want.last);
      $display("  got kind=%0d start=%0d len=%0d value=%0d last=%0b",
               got.kind, got.start, got.length, got.value, got.last);
    end
  endtask

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (rst_n && pop && !empty) begin
      got = {out_token_kind, out_token_start, out_token_length, out_number_value,
             out_last_of_run};
      if (expected_tokens.size() == 0) begin
        report_token("token with none expected", '0, got);
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind || got.start !== want.start ||
            got.length !== want.length || got.value !== want.value ||
            got.last !== want.last)
          report_token("token mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------- random content

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(3) == 0) return 8'("0" + $urandom_range(9));
    return rand_letter();
  endfunction

  // Any string body byte: nonzero, not a quote, high bit included
  function automatic logic [7:0] rand_string_char();
    logic [7:0] r;
    r = 8'($urandom_range(1, 254));
    if (r >= CH_QUOTE) r++;
    return r;
  endfunction

  task automatic send_random_piece();
    int n;
    case ($urandom_range(11))
      0, 1: send_char_safe(PUNCT_TEXT[$urandom_range(14)]);
      2: repeat ($urandom_range(1, 3)) send_char_safe(CH_SPACE);
      3: begin
        send_char_safe(CH_DOLLAR);
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(18, 22)) send_char_safe("9");
        end else begin
          n = ($urandom_range(7) == 0) ? $urandom_range(0, 22) : $urandom_range(0, 6);
          repeat (n) send_char_safe(8'("0" + $urandom_range(9)));
        end
      end
      4: begin
        send_char_safe(rand_letter());
        repeat ($urandom_range(0, 9)) send_char_safe(rand_word_char());
      end
      5: begin
        foreach (near_words[i]) if (i == $urandom_range(7)) send_text(near_words[i]);
        send_char_safe(CH_SPACE);
      end
      6: begin
        send_char_safe(CH_QUOTE);
        repeat ($urandom_range(0, 12)) send_char_safe(rand_string_char());
        send_char_safe(CH_QUOTE);
      end
      7: begin
        send_char_safe(CH_PERCENT);
        if ($urandom_range(3) != 0) begin
          send_char_safe(rand_letter());
          repeat ($urandom_range(0, 6)) send_char_safe(rand_word_char());
        end
      end
      8: send_char_safe(CH_NUL);
      9: send_char_safe(8'($urandom_range(255)));
      // broken starts: a prefix with whatever follows
      default: begin
        case ($urandom_range(2))
          0: send_char_safe(CH_DOLLAR);
          1: send_char_safe(CH_PERCENT);
          default: send_char_safe(CH_QUOTE);
        endcase
        send_char_safe(8'($urandom_range(255)));
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_punctuation();
    send_text(PUNCT_TEXT);
    send_char(CH_NUL);
  endtask

  // Empty varname, empty number, both keywords, a string, then an identifier
  task automatic test_words();
    send_text("%$ uqword return\"hi\"a_9");
    send_char(CH_NUL);
  endtask

  // Largest value exactly, then one past it
  task automatic test_number_limit();
    send_text("$9223372036854775807 $9223372036854775808");
    send_char(CH_NUL);
  endtask

  // A string with arbitrary body bytes, then tokens at offsets after it
  task automatic test_long_text();
    send_char(CH_QUOTE);
    repeat (LONG_BODY) send_char(rand_string_char());
    send_char(CH_QUOTE);
    send_text("ab $12 %v +");
    send_char(CH_NUL);
  endtask

  // Receiver holds off while bytes keep coming; the token queue fills up
  task automatic test_backpressure();
    stall_requests++;
    repeat (15) begin
      send_char("x");
      send_char(PUNCT_TEXT[$urandom_range(14)]);
    end
  endtask

  task automatic test_random_text();
    int base;
    base = chars_sent;
    while (chars_sent - base < 290) begin
      steady = (chars_sent - base >= 140) && (chars_sent - base < 260);
      send_random_piece();
    end
    steady = 1'b0;
    if (scanner.mode == M_STRING) send_char(CH_QUOTE);
    send_char(CH_NUL);
  endtask

  // One error per run: bad char or unterminated string, then bytes that are ignored
  task automatic test_halt();
    send_text("abc");
    case ($urandom_range(3))
      0: send_char(8'($urandom_range(128, 255)));
      1: send_char("#");
      2: send_char("@");
      default: begin
        send_text("\"op");
        send_char(CH_NUL);
      end
    endcase
    repeat (6) send_char(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_punctuation();
    test_words();
    test_number_limit();
    test_long_text();
    test_backpressure();
    test_random_text();
    test_halt();

    // drain
    @(negedge clk);
    push <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/stt_pkg.sv
src/stt_front.sv
src/stt_queue.sv
src/stt_back.sv
src/source_text_tokenizer.sv
bench/tb_top.sv
